/* rtl/ptwe_pkg.sv */
// Shared constants and command codes for the page table walker.
package ptwe_pkg;

	localparam int OFFSET_BITS_DEF  = 3;
	localparam int TABLE_LEVELS_DEF = 3;
	localparam int FRAME_COUNT_DEF  = 16;
	localparam int WORD_BITS_DEF    = 32;

	// Width of the virtual address field on the input stream.
	localparam int VA_IN_BITS = 12;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

endpackage

/* rtl/ptwe_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ptwe_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/page_table_walker_with_eviction_core.sv */
// Top level: page table walker with frame allocation, eviction and swap.
//
// Usage:
//   Input stream s_*: one transfer per access. s_tuser is the command (read or
//   write), s_tdata carries the virtual word address and the write word.
//   Output stream m_*: exactly one transfer per access; m_tdata is the word
//   read, or zero for a write, an out-of-range address or a dropped access.
//   The address is resolved by walking the table tree in frame memory, one
//   memory read per level, then one data access. The block is ready for the
//   next transfer once the result appears. A missing entry runs a depth-first
//   search over the tree, reading each entry of a table in turn and scoring
//   each leaf entry by its distance to the target page. An unlink scan and a
//   victim copy to swap follow where a used frame is taken over, then a frame
//   fill, each word by word.
//   After reset the swap memory is cleared, one word a cycle, all
//   min(2^(OFFSET_BITS*(TABLE_LEVELS+1)), 4096) words (4096 by default);
//   frame 0 is cleared in the same pass. s_tready stays low meanwhile.
//   One access is worked on at a time. A finished result waits in the output
//   register while the next access is already taken in; if the receiver
//   stalls, the block holds at the end of that next access until the output
//   register frees up.
module page_table_walker_with_eviction_core #(
	parameter int OFFSET_BITS  = ptwe_pkg::OFFSET_BITS_DEF,
	parameter int TABLE_LEVELS = ptwe_pkg::TABLE_LEVELS_DEF,
	parameter int FRAME_COUNT  = ptwe_pkg::FRAME_COUNT_DEF,
	parameter int WORD_BITS    = ptwe_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [11:0] virtual_address, [43:12] write_data, rest zero
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] read_data
);

	import ptwe_pkg::*;

	localparam int PW        = 1 << OFFSET_BITS;
	localparam int FB        = $clog2(FRAME_COUNT);
	localparam int FM_DEPTH  = FRAME_COUNT * PW;
	localparam int FM_AW     = FB + OFFSET_BITS;
	localparam int VA_BITS   = OFFSET_BITS * (TABLE_LEVELS + 1);
	localparam int PAGE_BITS = OFFSET_BITS * TABLE_LEVELS;
	localparam int SW_BITS   = (VA_BITS < VA_IN_BITS) ? VA_BITS : VA_IN_BITS;
	localparam int SW_DEPTH  = 1 << SW_BITS;
	localparam int LW        = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
	localparam int DW        = $clog2(TABLE_LEVELS + 1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_WALK_RD,
		S_WALK_CHK,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_DIST,
		S_CMP,
		S_SRCH_ADV,
		S_FREE_PAR,
		S_PICK,
		S_UNL_RD,
		S_UNL_CHK,
		S_COPY_RD,
		S_COPY_WR,
		S_FILL_RD,
		S_FILL_WR,
		S_LINK,
		S_DATA,
		S_DATA_RD,
		S_DONE
	} state_t;

	state_t state_q;

	logic                   cmd_q;
	logic [VA_IN_BITS-1:0]  va_q;
	logic signed [31:0]     wd_q;
	logic [DW-1:0]          d_q;
	logic [FB-1:0]          cur_q;
	logic [FB-1:0]          new_q;
	logic [FB-1:0]          active_q;
	logic [LW-1:0]          lvl_q;
	logic [FB-1:0]          node_q [TABLE_LEVELS];
	logic [OFFSET_BITS-1:0] idx_q  [TABLE_LEVELS];
	logic                   nemp_q [TABLE_LEVELS];
	logic [FB-1:0]          top_q;
	logic                   best_valid_q;
	logic [FB-1:0]          best_frame_q;
	logic [FB-1:0]          best_par_q;
	logic [PAGE_BITS-1:0]   best_page_q;
	logic [PAGE_BITS-1:0]   best_dist_q;
	logic [FB-1:0]          cand_frame_q;
	logic [FB-1:0]          cand_par_q;
	logic [PAGE_BITS-1:0]   cand_page_q;
	logic [PAGE_BITS-1:0]   dist_q;
	logic [FB-1:0]          unl_par_q;
	logic [FB-1:0]          unl_child_q;
	logic                   unl_victim_q;
	logic [OFFSET_BITS-1:0] cnt_q;
	logic [31:0]            res_q;
	logic                   out_valid_q;
	logic [31:0]            out_data_q;
	logic                   clr_busy_q;
	logic [SW_BITS-1:0]     clr_q;

	logic                 fm_we;
	logic [FM_AW-1:0]     fm_waddr;
	logic [WORD_BITS-1:0] fm_wdata;
	logic [FM_AW-1:0]     fm_raddr;
	logic [WORD_BITS-1:0] fm_rdata;
	logic                 sw_we;
	logic [SW_BITS-1:0]   sw_waddr;
	logic [WORD_BITS-1:0] sw_wdata;
	logic [SW_BITS-1:0]   sw_raddr;
	logic [WORD_BITS-1:0] sw_rdata;

	logic [OFFSET_BITS-1:0] walk_idx;
	logic [OFFSET_BITS-1:0] page_off;
	logic [PAGE_BITS-1:0]   tgt_page;
	logic [PAGE_BITS-1:0]   leaf_path;
	logic [PAGE_BITS-1:0]   diff_a;
	logic [PAGE_BITS-1:0]   diff_b;
	logic [FB-1:0]          rd_frame;
	logic                   rd_zero;
	logic                   leaf_lvl;
	logic                   top_room;
	logic                   va_wide;
	logic [FB-1:0]          srch_node;
	logic [OFFSET_BITS-1:0] srch_idx;
	logic                   srch_nemp;

	assign s_tready = (state_q == S_IDLE) && !clr_busy_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign page_off  = va_q[OFFSET_BITS-1:0];
	assign tgt_page  = PAGE_BITS'(va_q >> OFFSET_BITS);
	assign rd_frame  = fm_rdata[FB-1:0];
	assign rd_zero   = (fm_rdata == '0);
	assign leaf_lvl  = (d_q == DW'(TABLE_LEVELS - 1));
	assign top_room  = (({1'b0, top_q} + 1'b1) < (FB + 1)'(FRAME_COUNT));
	assign diff_a    = cand_page_q - tgt_page;
	assign diff_b    = tgt_page - cand_page_q;
	assign srch_node = node_q[lvl_q];
	assign srch_idx  = idx_q[lvl_q];
	assign srch_nemp = nemp_q[lvl_q];

	always_comb begin
		va_wide = 1'b0;
		if (VA_BITS < VA_IN_BITS) begin
			va_wide = ((va_q >> VA_BITS) != '0);
		end
	end

	always_comb begin
		walk_idx = '0;
		for (int k = 0; k < TABLE_LEVELS; k++) begin
			if (d_q == DW'(k)) begin
				walk_idx = OFFSET_BITS'(va_q >> ((TABLE_LEVELS - k) * OFFSET_BITS));
			end
		end
	end

	// Page number of the leaf under the current search position, root index on top.
	always_comb begin
		leaf_path = '0;
		for (int k = 0; k < TABLE_LEVELS; k++) begin
			leaf_path[(TABLE_LEVELS - 1 - k) * OFFSET_BITS +: OFFSET_BITS] = idx_q[k];
		end
	end

	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = '0;
		fm_wdata = '0;
		if (clr_busy_q) begin
			fm_we    = (clr_q < SW_BITS'(PW));
			fm_waddr = {FB'(0), clr_q[OFFSET_BITS-1:0]};
		end else begin
			case (state_q)
				S_UNL_CHK: begin
					fm_we    = (fm_rdata == WORD_BITS'(unl_child_q));
					fm_waddr = {unl_par_q, cnt_q};
				end
				S_FILL_WR: begin
					fm_we    = 1'b1;
					fm_waddr = {new_q, cnt_q};
					fm_wdata = leaf_lvl ? sw_rdata : '0;
				end
				S_LINK: begin
					fm_we    = 1'b1;
					fm_waddr = {cur_q, walk_idx};
					fm_wdata = WORD_BITS'(new_q);
				end
				S_DATA: begin
					fm_we    = (cmd_q == CMD_WRITE);
					fm_waddr = {cur_q, page_off};
					fm_wdata = WORD_BITS'(wd_q);
				end
				default: begin
					fm_we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_WALK_RD: fm_raddr = {cur_q, walk_idx};
			S_SRCH_RD: fm_raddr = {srch_node, srch_idx};
			S_UNL_RD:  fm_raddr = {unl_par_q, cnt_q};
			S_COPY_RD: fm_raddr = {best_frame_q, cnt_q};
			S_DATA:    fm_raddr = {cur_q, page_off};
			default:   fm_raddr = '0;
		endcase
	end

	always_comb begin
		sw_we    = 1'b0;
		sw_waddr = clr_q;
		sw_wdata = '0;
		if (clr_busy_q) begin
			sw_we = 1'b1;
		end else if (state_q == S_COPY_WR) begin
			sw_we    = 1'b1;
			sw_waddr = SW_BITS'({best_page_q, cnt_q});
			sw_wdata = fm_rdata;
		end
	end

	assign sw_raddr = SW_BITS'({tgt_page, cnt_q});

	ptwe_ram #(
		.DEPTH(FM_DEPTH),
		.WIDTH(WORD_BITS)
	) u_frame_ram (
		.clk  (clk),
		.we   (fm_we),
		.waddr(fm_waddr),
		.wdata(fm_wdata),
		.raddr(fm_raddr),
		.rdata(fm_rdata)
	);

	ptwe_ram #(
		.DEPTH(SW_DEPTH),
		.WIDTH(WORD_BITS)
	) u_swap_ram (
		.clk  (clk),
		.we   (sw_we),
		.waddr(sw_waddr),
		.wdata(sw_wdata),
		.raddr(sw_raddr),
		.rdata(sw_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			clr_busy_q   <= 1'b1;
			clr_q        <= '0;
			best_valid_q <= 1'b0;
		end else begin
			// Load the output register when it is free or drains this cycle.
			if ((state_q == S_DONE) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res_q;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						cmd_q   <= s_tuser;
						va_q    <= s_tdata[VA_IN_BITS-1:0];
						wd_q    <= s_tdata[VA_IN_BITS +: 32];
						d_q     <= '0;
						cur_q   <= '0;
						res_q   <= '0;
						if ((VA_BITS < VA_IN_BITS) &&
						    ((s_tdata[VA_IN_BITS-1:0] >> VA_BITS) != '0)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_WALK_RD;
						end
					end
				end
				S_WALK_RD: begin
					state_q <= va_wide ? S_DONE : S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (!rd_zero) begin
						cur_q   <= rd_frame;
						d_q     <= d_q + 1'b1;
						state_q <= leaf_lvl ? S_DATA : S_WALK_RD;
					end else begin
						// Missing entry: start the depth-first search at the root.
						active_q     <= cur_q;
						lvl_q        <= '0;
						node_q[0]    <= '0;
						idx_q[0]     <= '0;
						nemp_q[0]    <= 1'b0;
						top_q        <= '0;
						best_valid_q <= 1'b0;
						state_q      <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CHK;
				end
				S_SRCH_CHK: begin
					if (rd_zero) begin
						state_q <= S_SRCH_ADV;
					end else begin
						nemp_q[lvl_q] <= 1'b1;
						if (rd_frame > top_q) begin
							top_q <= rd_frame;
						end
						if (lvl_q == LW'(TABLE_LEVELS - 1)) begin
							cand_frame_q <= rd_frame;
							cand_par_q   <= srch_node;
							cand_page_q  <= leaf_path;
							state_q      <= S_DIST;
						end else begin
							node_q[lvl_q + 1'b1] <= rd_frame;
							idx_q[lvl_q + 1'b1]  <= '0;
							nemp_q[lvl_q + 1'b1] <= 1'b0;
							lvl_q                <= lvl_q + 1'b1;
							state_q              <= S_SRCH_RD;
						end
					end
				end
				S_DIST: begin
					dist_q  <= (diff_a < diff_b) ? diff_a : diff_b;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Keep the first leaf on ties.
					if (!best_valid_q || (best_dist_q < dist_q)) begin
						best_valid_q <= 1'b1;
						best_frame_q <= cand_frame_q;
						best_par_q   <= cand_par_q;
						best_page_q  <= cand_page_q;
						best_dist_q  <= dist_q;
					end
					state_q <= S_SRCH_ADV;
				end
				S_SRCH_ADV: begin
					if (srch_idx != OFFSET_BITS'(PW - 1)) begin
						idx_q[lvl_q] <= srch_idx + 1'b1;
						state_q      <= S_SRCH_RD;
					end else if (lvl_q == '0) begin
						state_q <= S_PICK;
					end else if (!srch_nemp && (srch_node != active_q)) begin
						unl_child_q  <= srch_node;
						new_q        <= srch_node;
						unl_victim_q <= 1'b0;
						lvl_q        <= lvl_q - 1'b1;
						state_q      <= S_FREE_PAR;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						state_q <= S_SRCH_ADV;
					end
				end
				S_FREE_PAR: begin
					unl_par_q <= srch_node;
					cnt_q     <= '0;
					state_q   <= S_UNL_RD;
				end
				S_PICK: begin
					cnt_q <= '0;
					if (top_room) begin
						new_q   <= top_q + 1'b1;
						state_q <= S_FILL_RD;
					end else if (best_valid_q) begin
						unl_par_q    <= best_par_q;
						unl_child_q  <= best_frame_q;
						new_q        <= best_frame_q;
						unl_victim_q <= 1'b1;
						state_q      <= S_UNL_RD;
					end else begin
						// No frame to give: drop the access.
						state_q <= S_DONE;
					end
				end
				S_UNL_RD: begin
					state_q <= S_UNL_CHK;
				end
				S_UNL_CHK: begin
					if ((fm_rdata == WORD_BITS'(unl_child_q)) ||
					    (cnt_q == OFFSET_BITS'(PW - 1))) begin
						cnt_q   <= '0;
						state_q <= unl_victim_q ? S_COPY_RD : S_FILL_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_UNL_RD;
					end
				end
				S_COPY_RD: begin
					state_q <= S_COPY_WR;
				end
				S_COPY_WR: begin
					if (cnt_q == OFFSET_BITS'(PW - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FILL_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_COPY_RD;
					end
				end
				S_FILL_RD: begin
					state_q <= S_FILL_WR;
				end
				S_FILL_WR: begin
					if (cnt_q == OFFSET_BITS'(PW - 1)) begin
						state_q <= S_LINK;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_FILL_RD;
					end
				end
				S_LINK: begin
					cur_q   <= new_q;
					d_q     <= d_q + 1'b1;
					state_q <= leaf_lvl ? S_DATA : S_WALK_RD;
				end
				S_DATA: begin
					state_q <= (cmd_q == CMD_WRITE) ? S_DONE : S_DATA_RD;
				end
				S_DATA_RD: begin
					res_q   <= 32'(signed'(fm_rdata));
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("input taken during swap clearing pass");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != S_IDLE))
		else $error("accepted access did not start");

	a_victim_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && best_valid_q) |-> (best_frame_q != '0))
		else $error("eviction victim is the root frame");

	a_done_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || m_tready)) |=> out_valid_q)
		else $error("finished access produced no result");
`endif

endmodule
